// ===== rtl/core/alir_pkg.sv =====
package alir_pkg;

  // Defaults for the top-level parameters.
  localparam int unsigned CAPACITY_DEF    = 64;
  localparam int unsigned ENTRY_WIDTH_DEF = 32;

  // The position bus inside the block is wide enough for the largest
  // supported capacity.
  localparam int unsigned CAPACITY_MAX = 4096;
  localparam int unsigned AT_W         = $clog2(CAPACITY_MAX + 1);

  // Field widths on the stream ports.
  localparam int unsigned OP_W     = 3;
  localparam int unsigned POS_W    = 7;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned STATUS_W = 2;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_INS_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_INS_AT    = 3'd2;
  localparam logic [OP_W-1:0] OP_REM_FRONT = 3'd3;
  localparam logic [OP_W-1:0] OP_REM_BACK  = 3'd4;
  localparam logic [OP_W-1:0] OP_REM_AT    = 3'd5;
  localparam logic [OP_W-1:0] OP_READ_AT   = 3'd6;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd3;

  // Shift command broadcast to every cell of the row.
  typedef struct packed {
    logic            ins;
    logic            rem;
    logic [AT_W-1:0] at;
  } ctrl_t;

endpackage

// ===== rtl/core/alir_cell.sv =====
module alir_cell #(
  parameter int unsigned INDEX       = 0,
  parameter int unsigned ENTRY_WIDTH = alir_pkg::ENTRY_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  alir_pkg::ctrl_t        ctrl_i,
  input  logic [ENTRY_WIDTH-1:0] new_word_i,
  input  logic [ENTRY_WIDTH-1:0] left_word_i,
  input  logic [ENTRY_WIDTH-1:0] right_word_i,
  output logic [ENTRY_WIDTH-1:0] word_o,
  output logic [ENTRY_WIDTH-1:0] rd_word_o
);
  import alir_pkg::*;

  localparam logic [AT_W-1:0] Idx = AT_W'(INDEX);

  logic [ENTRY_WIDTH-1:0] word_d, word_q;

  // On insert, cells above the target take their lower neighbor and the
  // target cell takes the new word; on remove, cells from the target up
  // take their upper neighbor.
  always_comb begin
    word_d = word_q;
    if (ctrl_i.ins) begin
      if (Idx > ctrl_i.at) begin
        word_d = left_word_i;
      end else if (Idx == ctrl_i.at) begin
        word_d = new_word_i;
      end
    end else if (ctrl_i.rem) begin
      if (Idx >= ctrl_i.at) begin
        word_d = right_word_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o    = word_q;
  assign rd_word_o = (Idx == ctrl_i.at) ? word_q : '0;

endmodule

// ===== rtl/core/array_list_insert_remove_top.sv =====
// The result beat of an accepted input beat is registered and appears in the next cycle.
// Throughput: one operation per cycle while the result stream is not stalled; every cell
// of the row compares its index with the target and shifts in the same cycle.
// Reset: the entry count and the output valid clear at once. The entry cells
// are not cleared and need no clearing pass; only entries below the count
// are ever read.
module array_list_insert_remove_top #(
  parameter int unsigned CAPACITY    = alir_pkg::CAPACITY_DEF,
  parameter int unsigned ENTRY_WIDTH = alir_pkg::ENTRY_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Operation stream.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [2:0] op, [9:3] position, [41:10] entry_value, [47:42] zero.
  input  logic [47:0] s_axis_tdata_i,
  // Result stream.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [31:0] entry_out, [38:32] entry_count, [40:39] status, [47:41] zero.
  output logic [47:0] m_axis_tdata_o,
  // [0] data_valid.
  output logic        m_axis_tuser_o
);
  import alir_pkg::*;

  // The count must also hold the capacity itself.
  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  // Unpack the input beat.
  logic [OP_W-1:0]   op;
  logic [POS_W-1:0]  position;
  logic [WORD_W-1:0] entry_value;

  assign op          = s_axis_tdata_i[2:0];
  assign position    = s_axis_tdata_i[9:3];
  assign entry_value = s_axis_tdata_i[41:10];

  // The entry word keeps its low ENTRY_WIDTH bits; a wider store is
  // zero-filled above the 32 bits that the port carries.
  logic [ENTRY_WIDTH+WORD_W-1:0] in_ext;
  logic [ENTRY_WIDTH-1:0]        new_word;

  assign in_ext   = (ENTRY_WIDTH + WORD_W)'(entry_value);
  assign new_word = in_ext[ENTRY_WIDTH-1:0];

  // Entry count.
  logic [CntW-1:0] cnt_d, cnt_q;
  logic [AT_W-1:0] cnt_at, pos_at;

  assign cnt_at = AT_W'(cnt_q);
  assign pos_at = AT_W'(position);

  // The output register frees up as soon as its beat is taken, so the
  // block accepts a new operation in that same cycle.
  logic fire;

  assign s_axis_tready_o = !m_axis_tvalid_o || m_axis_tready_i;
  assign fire            = s_axis_tvalid_i && s_axis_tready_o;

  // Decode the operation into a target index and a kind, then check it
  // against the current count. A full list is checked before the position.
  logic                is_ins, is_get, is_read;
  logic [AT_W-1:0]     at;
  logic [STATUS_W-1:0] status;
  logic                ins_ok, get_ok;

  always_comb begin
    is_ins  = 1'b0;
    is_get  = 1'b0;
    is_read = 1'b0;
    at      = '0;
    unique case (op)
      OP_INS_FRONT: begin
        is_ins = 1'b1;
      end
      OP_INS_BACK: begin
        is_ins = 1'b1;
        at     = cnt_at;
      end
      OP_INS_AT: begin
        is_ins = 1'b1;
        at     = pos_at;
      end
      OP_REM_FRONT: begin
        is_get = 1'b1;
      end
      OP_REM_BACK: begin
        is_get = 1'b1;
        at     = cnt_at - AT_W'(1);
      end
      OP_REM_AT: begin
        is_get = 1'b1;
        at     = pos_at;
      end
      OP_READ_AT: begin
        is_get  = 1'b1;
        is_read = 1'b1;
        at      = pos_at;
      end
      default: begin
        // The unused code does nothing and reports success.
      end
    endcase
  end

  always_comb begin
    status = ST_OK;
    ins_ok = 1'b0;
    get_ok = 1'b0;
    if (is_ins) begin
      if (cnt_at == AT_W'(CAPACITY)) begin
        status = ST_FULL;
      end else if (at > cnt_at) begin
        status = ST_BADPOS;
      end else begin
        ins_ok = 1'b1;
      end
    end else if (is_get) begin
      if (cnt_q == '0) begin
        status = ST_EMPTY;
      end else if (at >= cnt_at) begin
        status = ST_BADPOS;
      end else begin
        get_ok = 1'b1;
      end
    end
  end

  // Command for the row of cells; reads leave the row untouched.
  ctrl_t ctrl;

  assign ctrl.ins = fire && ins_ok;
  assign ctrl.rem = fire && get_ok && !is_read;
  assign ctrl.at  = at;

  always_comb begin
    cnt_d = cnt_q;
    if (ctrl.ins) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (ctrl.rem) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // The row of cells. Each cell holds one entry and sees its two
  // neighbors; the bottom cell has no lower neighbor and the top cell
  // keeps its own word on a remove.
  logic [ENTRY_WIDTH-1:0] cell_word [CAPACITY];
  logic [ENTRY_WIDTH-1:0] cell_rd   [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ENTRY_WIDTH-1:0] left_word, right_word;

    if (i == 0) begin : g_bottom
      assign left_word = '0;
    end else begin : g_lower
      assign left_word = cell_word[i-1];
    end

    if (i == CAPACITY - 1) begin : g_top
      assign right_word = cell_word[i];
    end else begin : g_upper
      assign right_word = cell_word[i+1];
    end

    alir_cell #(
      .INDEX       (i),
      .ENTRY_WIDTH (ENTRY_WIDTH)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .new_word_i   (new_word),
      .left_word_i  (left_word),
      .right_word_i (right_word),
      .word_o       (cell_word[i]),
      .rd_word_o    (cell_rd[i])
    );
  end

  // Only the addressed cell drives a nonzero read word, so an OR over the
  // row picks out the target entry.
  logic [ENTRY_WIDTH-1:0] rd_word;

  always_comb begin
    rd_word = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_word = rd_word | cell_rd[i];
    end
  end

  logic [ENTRY_WIDTH+WORD_W-1:0] rd_ext;
  logic [WORD_W-1:0]             data_out;

  assign rd_ext   = (ENTRY_WIDTH + WORD_W)'(rd_word);
  assign data_out = get_ok ? rd_ext[WORD_W-1:0] : '0;

  // Output register. Only its valid flag is reset; the payload is loaded
  // with every accepted beat.
  logic                out_valid_q;
  logic                dvalid_q;
  logic [WORD_W-1:0]   data_q;
  logic [COUNT_W-1:0]  count_q;
  logic [STATUS_W-1:0] status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      dvalid_q <= get_ok;
      data_q   <= data_out;
      count_q  <= COUNT_W'(cnt_d);
      status_q <= status;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = dvalid_q;
  assign m_axis_tdata_o  = {7'd0, status_q, count_q, data_q};

  // The list never grows past its capacity.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(CAPACITY))
    else $error("entry count above capacity");

  // A successful insert raises the count by exactly one.
  a_ins_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.ins |=> cnt_q == $past(cnt_q) + CntW'(1))
    else $error("insert did not raise the count by one");

  // A result that is not ok never carries a data word.
  a_fail_nodata: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (status_q != ST_OK) |-> !m_axis_tuser_o)
    else $error("failed operation returned a data word");

  // A result without a data word carries an all-zero entry word.
  a_nodata_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> data_q == '0)
    else $error("entry word not zero without data valid");

endmodule
